// ===== src/semt_pkg.sv =====
// shared types and constants for the semaphore table
package semt_pkg;

    localparam int SEM_COUNT  = 16;
    localparam int SemIdxW    = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int CntW       = 32;

    typedef enum logic [1:0] {
        MODE_OPEN  = 2'd0,
        MODE_POST  = 2'd1,
        MODE_WAIT  = 2'd2,
        MODE_CLOSE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ALREADY = 2'd1,
        ST_ERROR   = 2'd2,
        ST_BLOCK   = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]      mode;
        logic [7:0]      sem_index;
        logic [CntW-1:0] amount;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic [CntW-1:0] count;
        logic            wake;
    } t_rsp;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic commit;
    } t_dp_cmd;

endpackage

// ===== src/semaphore_table_core.sv =====
// top level of the counting semaphore table
// usage
//   request channel: i_in_valid / o_in_stall carry one request (mode, sem_index,
//   amount); it is taken at a clock edge where valid is high and stall is low
//   response channel: o_out_valid / i_out_stall carry one response (status,
//   count, wake) for every request, in request order
// request path and throughput
//   the request is registered in the request register; then, once the response
//   slot is free, the table entry is read, updated and written back while the
//   response register loads, and the response is shown from that register
//   the block takes no new request until the current one has committed; the
//   bound is the single read-modify-write of the register table
// stall behavior
//   a pending response holds while i_out_stall is high; a new request is still
//   taken, but its update waits until the response slot frees up
// reset
//   synchronous active-low reset closes every entry and zeroes every count,
//   and drops all valid flags; no clearing pass is needed
module semaphore_table_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  semt_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output semt_pkg::t_rsp o_out_data
);

    // command bundle from controller to datapath
    semt_pkg::t_dp_cmd w_cmd;

    semt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // table, request register and response register
    semt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_in_data),
        .o_rsp   (o_out_data)
    );

endmodule

// ===== src/semt_ctrl.sv =====
// controller state machine for the semaphore table
module semt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output semt_pkg::t_dp_cmd o_cmd
);

    semt_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    // output slot is empty or drains this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            semt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = semt_pkg::S_EXEC;
                end
            end
            semt_pkg::S_EXEC: begin
                if (w_out_free) begin
                    n_state = semt_pkg::S_IDLE;
                end
            end
            default: n_state = semt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = 1'b1;
        o_cmd        = '0;
        n_out_valid  = r_out_valid && i_out_stall;
        unique case (r_state)
            semt_pkg::S_IDLE: begin
                o_in_stall     = 1'b0;
                o_cmd.load_req = i_in_valid;
            end
            semt_pkg::S_EXEC: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= semt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/semt_dp.sv =====
// datapath: request register, semaphore table and result register
module semt_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  semt_pkg::t_dp_cmd i_cmd,
    input  semt_pkg::t_req    i_req,
    output semt_pkg::t_rsp    o_rsp
);

    semt_pkg::t_req r_req;
    semt_pkg::t_rsp r_rsp, n_rsp;

    logic [semt_pkg::CntW-1:0]      r_counts [semt_pkg::SEM_COUNT];
    logic [semt_pkg::SEM_COUNT-1:0] r_open;

    logic                         w_idx_ok;
    logic [semt_pkg::SemIdxW-1:0] w_idx;
    logic                         w_is_open;
    logic [semt_pkg::CntW-1:0]    w_cur;
    logic [semt_pkg::CntW:0]      w_sum;
    logic [semt_pkg::CntW:0]      w_diff;
    logic [semt_pkg::CntW-1:0]    n_cnt;
    logic                         n_open;

    assign w_idx_ok  = {1'b0, r_req.sem_index} < 9'(semt_pkg::SEM_COUNT);
    assign w_idx     = r_req.sem_index[semt_pkg::SemIdxW-1:0];
    assign w_is_open = w_idx_ok ? r_open[w_idx] : 1'b0;
    assign w_cur     = w_idx_ok ? r_counts[w_idx] : '0;
    assign w_sum     = {1'b0, w_cur} + {1'b0, r_req.amount};
    assign w_diff    = {1'b0, w_cur} - {1'b0, r_req.amount};

    always_comb begin
        n_cnt        = w_cur;
        n_open       = w_is_open;
        n_rsp.status = semt_pkg::ST_ERROR;
        n_rsp.wake   = 1'b0;
        if (w_idx_ok) begin
            if (r_req.mode == semt_pkg::MODE_OPEN) begin
                if (w_is_open) begin
                    n_rsp.status = semt_pkg::ST_ALREADY;
                end else begin
                    n_cnt        = r_req.amount;
                    n_open       = 1'b1;
                    n_rsp.status = semt_pkg::ST_OK;
                end
            end else if (!w_is_open) begin
                n_rsp.status = semt_pkg::ST_ERROR;
            end else begin
                case (r_req.mode)
                    semt_pkg::MODE_POST: begin
                        // saturate on carry out
                        n_cnt        = w_sum[semt_pkg::CntW] ? '1 : w_sum[semt_pkg::CntW-1:0];
                        n_rsp.status = semt_pkg::ST_OK;
                        n_rsp.wake   = 1'b1;
                    end
                    semt_pkg::MODE_WAIT: begin
                        if (!w_diff[semt_pkg::CntW]) begin
                            n_cnt        = w_diff[semt_pkg::CntW-1:0];
                            n_rsp.status = semt_pkg::ST_OK;
                        end else begin
                            n_rsp.status = semt_pkg::ST_BLOCK;
                        end
                    end
                    default: begin
                        n_open       = 1'b0;
                        n_rsp.status = semt_pkg::ST_OK;
                        n_rsp.wake   = 1'b1;
                    end
                endcase
            end
        end
        n_rsp.count = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
            for (int i = 0; i < semt_pkg::SEM_COUNT; i++) begin
                r_counts[i] <= '0;
            end
        end else if (i_cmd.commit && w_idx_ok) begin
            r_open[w_idx]   <= n_open;
            r_counts[w_idx] <= n_cnt;
        end
    end

    assign o_rsp = r_rsp;

endmodule
